@@ hw/rtl/morse_letter_keyer_top_defines.svh @@
// ----------------------------------------------------------------------------
// Morse letter keyer assertion macros
// Clocked property checks shared by the keyer modules.
// ----------------------------------------------------------------------------
`ifndef MORSE_LETTER_KEYER_TOP_DEFINES_SVH
`define MORSE_LETTER_KEYER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check prop at every rising edge outside of reset
`define MLK_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check prop at every rising edge, reset included
`define MLK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MLK_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define MLK_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ hw/rtl/mlk_pkg.sv @@
// ----------------------------------------------------------------------------
// Morse letter keyer package
// Shared types, register codes and the letter pattern table.
// ----------------------------------------------------------------------------
package mlk_pkg;

    localparam int MLK_QUEUE_DEPTH = 2;
    localparam int MLK_TICK_W      = 16;
    localparam int MLK_S_TDATA_W   = 8;
    localparam int MLK_M_TDATA_W   = 24;
    localparam int MLK_CFG_ADDR_W  = 2;

    localparam logic [7:0] CHAR_A = 8'd65;
    localparam logic [7:0] CHAR_Z = 8'd90;

    localparam logic [MLK_TICK_W-1:0] DOT_TICKS_RST  = 16'd30;
    localparam logic [MLK_TICK_W-1:0] DASH_TICKS_RST = 16'd60;
    localparam logic [MLK_TICK_W-1:0] GAP_TICKS_RST  = 16'd200;

    typedef enum logic [MLK_CFG_ADDR_W-1:0] {
        CFG_DOT_TICKS  = 2'd0,
        CFG_DASH_TICKS = 2'd1,
        CFG_GAP_TICKS  = 2'd2
    } mlk_cfg_idx_t;

    typedef struct packed {
        logic [MLK_TICK_W-1:0] dot_ticks;
        logic [MLK_TICK_W-1:0] dash_ticks;
        logic [MLK_TICK_W-1:0] gap_ticks;
    } mlk_cfg_t;

    // one classified character: pattern is left aligned, first element in bit 3
    typedef struct packed {
        logic       is_letter;
        logic [1:0] last_elem;
        logic [3:0] pattern;
    } mlk_entry_t;

    // bits 6..4 element count, bits 3..0 elements (1 = dash), first in highest used bit
    function automatic logic [7:0] mlk_letter_code(input logic [4:0] idx);
        logic [7:0] code;
        case (idx)
            5'd0:    code = 8'h21;
            5'd1:    code = 8'h48;
            5'd2:    code = 8'h4A;
            5'd3:    code = 8'h34;
            5'd4:    code = 8'h10;
            5'd5:    code = 8'h42;
            5'd6:    code = 8'h36;
            5'd7:    code = 8'h40;
            5'd8:    code = 8'h20;
            5'd9:    code = 8'h47;
            5'd10:   code = 8'h35;
            5'd11:   code = 8'h44;
            5'd12:   code = 8'h23;
            5'd13:   code = 8'h22;
            5'd14:   code = 8'h37;
            5'd15:   code = 8'h46;
            5'd16:   code = 8'h4D;
            5'd17:   code = 8'h32;
            5'd18:   code = 8'h30;
            5'd19:   code = 8'h11;
            5'd20:   code = 8'h31;
            5'd21:   code = 8'h41;
            5'd22:   code = 8'h33;
            5'd23:   code = 8'h49;
            5'd24:   code = 8'h4B;
            5'd25:   code = 8'h4C;
            default: code = 8'h10;
        endcase
        return code;
    endfunction

endpackage

@@ hw/rtl/morse_letter_keyer_top.sv @@
// A character word passes the front register, the queue and the back-end registers.
// Throughput: one segment word per cycle while m_tready allows, set by the back-end
//   segment sequencer; a letter gives 2 to 8 words (two per element), other codes one.
// Character words are accepted every cycle while the entry queue has room.
// Reset: synchronous active-low aresetn empties the pipeline and queue and
//   restores dot_ticks 30, dash_ticks 60, gap_ticks 200.
// ----------------------------------------------------------------------------
// Morse letter keyer top level
// Keys character codes into timed pin segments, with tick length registers.
// ----------------------------------------------------------------------------
module morse_letter_keyer_top #(
    parameter int QueueDepth = mlk_pkg::MLK_QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mlk_pkg::MLK_CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [mlk_pkg::MLK_TICK_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mlk_pkg::MLK_S_TDATA_W-1:0]   s_tdata,   // [7:0] char_code
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mlk_pkg::MLK_M_TDATA_W-1:0]   m_tdata,   // [0] pin_level, [16:1] duration
    output logic                                m_tlast    // is_last
);
    import mlk_pkg::*;

    mlk_cfg_t   cfg_reg, cfg_next;
    logic       push_valid, push_ready;
    mlk_entry_t push_data;
    logic       q_valid, q_pop;
    mlk_entry_t q_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_DOT_TICKS:  cfg_next.dot_ticks  = cfg_wdata;
                CFG_DASH_TICKS: cfg_next.dash_ticks = cfg_wdata;
                CFG_GAP_TICKS:  cfg_next.gap_ticks  = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dot_ticks  <= DOT_TICKS_RST;
            cfg_reg.dash_ticks <= DASH_TICKS_RST;
            cfg_reg.gap_ticks  <= GAP_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mlk_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    mlk_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_data),
        .pop_ready  (q_pop)
    );

    mlk_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hw/rtl/mlk_front.sv @@
// ----------------------------------------------------------------------------
// Morse letter keyer front end
// Accepts character words and classifies them into pattern entries.
// ----------------------------------------------------------------------------
module mlk_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mlk_pkg::MLK_S_TDATA_W-1:0]   s_tdata,   // [7:0] char_code
    output logic                                push_valid,
    output mlk_pkg::mlk_entry_t                 push_data,
    input  logic                                push_ready
);
    import mlk_pkg::*;

    logic       valid_reg, valid_next;
    mlk_entry_t entry_reg, entry_next;
    mlk_entry_t entry_cls;
    logic [7:0] char_c;
    logic [7:0] char_off;
    logic [7:0] code;
    logic [2:0] count;
    logic [2:0] count_m1;
    logic       accept;

    assign s_tready   = !valid_reg || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = valid_reg;
    assign push_data  = entry_reg;

    always_comb begin
        char_c   = s_tdata[7:0];
        char_off = char_c - CHAR_A;
        code     = mlk_letter_code(char_off[4:0]);
        count    = code[6:4];
        count_m1 = count - 3'd1;
        entry_cls.is_letter = (char_c >= CHAR_A) && (char_c <= CHAR_Z);
        entry_cls.last_elem = count_m1[1:0];
        // left align so the first element sits in bit 3
        unique case (count)
            3'd1:    entry_cls.pattern = {code[0], 3'b000};
            3'd2:    entry_cls.pattern = {code[1:0], 2'b00};
            3'd3:    entry_cls.pattern = {code[2:0], 1'b0};
            default: entry_cls.pattern = code[3:0];
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (accept) begin
            valid_next = 1'b1;
            entry_next = entry_cls;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

endmodule

@@ hw/rtl/mlk_queue.sv @@
// ----------------------------------------------------------------------------
// Morse letter keyer entry queue
// Short FIFO that decouples classification from segment generation.
// ----------------------------------------------------------------------------
`include "morse_letter_keyer_top_defines.svh"

module mlk_queue #(
    parameter int Depth = mlk_pkg::MLK_QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    input  mlk_pkg::mlk_entry_t push_data,
    output logic                push_ready,
    output logic                pop_valid,
    output mlk_pkg::mlk_entry_t pop_data,
    input  logic                pop_ready
);
    import mlk_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    mlk_entry_t            store_reg [Depth];
    logic [PtrW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]       count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    `MLK_ASSERT_CLK(a_q_count_bound, aclk, aresetn, count_reg <= CntW'(Depth), "queue overfilled")
    `MLK_ASSERT_CLK(a_q_ptr_gap, aclk, aresetn, (count_reg == '0 || count_reg == CntW'(Depth)) |-> (wr_ptr_reg == rd_ptr_reg), "queue pointers out of step")

endmodule

@@ hw/rtl/mlk_back.sv @@
// ----------------------------------------------------------------------------
// Morse letter keyer back end
// Steps through one entry per character; one segment word a cycle unless m_tready stalls.
// ----------------------------------------------------------------------------
`include "morse_letter_keyer_top_defines.svh"

module mlk_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mlk_pkg::mlk_cfg_t                   cfg,
    input  logic                                q_valid,
    input  mlk_pkg::mlk_entry_t                 q_data,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mlk_pkg::MLK_M_TDATA_W-1:0]   m_tdata,   // [0] pin_level, [16:1] duration
    output logic                                m_tlast
);
    import mlk_pkg::*;

    localparam int PadW = MLK_M_TDATA_W - MLK_TICK_W - 1;

    logic                   active_reg, active_next;
    mlk_entry_t             cur_reg, cur_next;
    logic [3:0]             pattern_reg, pattern_next;
    logic [1:0]             elem_reg, elem_next;
    logic                   half_reg, half_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   level_reg, level_next;
    logic [MLK_TICK_W-1:0]  dur_reg, dur_next;
    logic                   last_reg, last_next;

    logic                   out_free;
    logic                   gen;
    logic                   seg_last;
    logic                   seg_level;
    logic [MLK_TICK_W-1:0]  seg_dur;

    assign out_free = !m_tvalid_reg || m_tready;
    assign gen      = active_reg && out_free;
    assign seg_last = !cur_reg.is_letter || (half_reg && (elem_reg == cur_reg.last_elem));
    assign q_pop    = q_valid && (!active_reg || (gen && seg_last));

    always_comb begin
        if (!cur_reg.is_letter) begin
            seg_level = 1'b1;
            seg_dur   = cfg.gap_ticks;
        end else begin
            seg_level = !half_reg;
            seg_dur   = pattern_reg[3] ? cfg.dash_ticks : cfg.dot_ticks;
        end
    end

    always_comb begin
        active_next   = active_reg;
        cur_next      = cur_reg;
        pattern_next  = pattern_reg;
        elem_next     = elem_reg;
        half_next     = half_reg;
        m_tvalid_next = m_tvalid_reg;
        level_next    = level_reg;
        dur_next      = dur_reg;
        last_next     = last_reg;

        if (gen) begin
            m_tvalid_next = 1'b1;
            level_next    = seg_level;
            dur_next      = seg_dur;
            last_next     = seg_last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (q_pop) begin
            active_next  = 1'b1;
            cur_next     = q_data;
            pattern_next = q_data.pattern;
            elem_next    = 2'd0;
            half_next    = 1'b0;
        end else if (gen) begin
            if (seg_last) begin
                active_next = 1'b0;
            end else if (half_reg) begin
                // advance to the next element
                half_next    = 1'b0;
                elem_next    = elem_reg + 2'd1;
                pattern_next = {pattern_reg[2:0], 1'b0};
            end else begin
                half_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            elem_reg     <= 2'd0;
            half_reg     <= 1'b0;
        end else begin
            active_reg   <= active_next;
            m_tvalid_reg <= m_tvalid_next;
            elem_reg     <= elem_next;
            half_reg     <= half_next;
        end
        cur_reg     <= cur_next;
        pattern_reg <= pattern_next;
        level_reg   <= level_next;
        dur_reg     <= dur_next;
        last_reg    <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PadW{1'b0}}, dur_reg, level_reg};
    assign m_tlast  = last_reg;

    `MLK_ASSERT_CLK(a_pop_needs_entry, aclk, aresetn, q_pop |-> q_valid, "pop from empty queue")
    `MLK_ASSERT_CLK(a_low_only_letter, aclk, aresetn, (active_reg && half_reg) |-> cur_reg.is_letter, "low half on a non-letter")
    `MLK_ASSERT_CLK(a_elem_in_range, aclk, aresetn, active_reg |-> (elem_reg <= cur_reg.last_elem), "element index past pattern")
    `MLK_ASSERT_CLK(a_low_after_high, aclk, aresetn, (gen && cur_reg.is_letter && !seg_last && !half_reg) |=> (half_reg && m_tvalid_reg && level_reg && !last_reg), "high half not followed by low half")

endmodule

@@ tb/keyer_segment_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyer segment checker
// Watches the character, segment and register channels of the keyer, keys
// every accepted character into its expected segments and compares each
// segment word that leaves the block against the oldest one waiting.
// ----------------------------------------------------------------------------
module keyer_segment_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mlk_pkg::MLK_CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [mlk_pkg::MLK_TICK_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [mlk_pkg::MLK_S_TDATA_W-1:0]   s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [mlk_pkg::MLK_M_TDATA_W-1:0]   m_tdata,
    input  logic                                m_tlast,
    output int                                  mismatches,
    output int                                  segs_pending,
    output int                                  segs_checked
);
    import mlk_pkg::*;

    typedef struct packed {
        logic                  level;
        logic [MLK_TICK_W-1:0] ticks;
        logic                  last;
    } segment_t;

    segment_t              segments_due[$];
    logic [MLK_TICK_W-1:0] dot_len;
    logic [MLK_TICK_W-1:0] dash_len;
    logic [MLK_TICK_W-1:0] gap_len;

    // International Morse pattern of an upper case letter
    function automatic string morse_pattern(input logic [7:0] c);
        case (c)
            "A": return ".-";
            "B": return "-...";
            "C": return "-.-.";
            "D": return "-..";
            "E": return ".";
            "F": return "..-.";
            "G": return "--.";
            "H": return "....";
            "I": return "..";
            "J": return ".---";
            "K": return "-.-";
            "L": return ".-..";
            "M": return "--";
            "N": return "-.";
            "O": return "---";
            "P": return ".--.";
            "Q": return "--.-";
            "R": return ".-.";
            "S": return "...";
            "T": return "-";
            "U": return "..-";
            "V": return "...-";
            "W": return ".--";
            "X": return "-..-";
            "Y": return "-.--";
            "Z": return "--..";
            default: return "";
        endcase
    endfunction

    function automatic void key_character(input logic [7:0] c);
        string                 pat;
        segment_t              seg;
        logic [MLK_TICK_W-1:0] len;
        if (c < CHAR_A || c > CHAR_Z) begin
            seg.level = 1'b1;
            seg.ticks = gap_len;
            seg.last  = 1'b1;
            segments_due.push_back(seg);
            return;
        end
        pat = morse_pattern(c);
        for (int i = 0; i < pat.len(); i++) begin
            len = (pat[i] == "-") ? dash_len : dot_len;
            // mark half, then space half
            seg.level = 1'b1;
            seg.ticks = len;
            seg.last  = 1'b0;
            segments_due.push_back(seg);
            seg.level = 1'b0;
            seg.last  = (i == pat.len() - 1);
            segments_due.push_back(seg);
        end
    endfunction

    always @(posedge aclk) begin
        segment_t want;
        int       errs;
        errs = 0;
        if (!aresetn) begin
            dot_len  = DOT_TICKS_RST;
            dash_len = DASH_TICKS_RST;
            gap_len  = GAP_TICKS_RST;
            segments_due.delete();
            mismatches   <= 0;
            segs_pending <= 0;
            segs_checked <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_DOT_TICKS:  dot_len  = cfg_wdata;
                    CFG_DASH_TICKS: dash_len = cfg_wdata;
                    CFG_GAP_TICKS:  gap_len  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                key_character(s_tdata);
            if (m_tvalid && m_tready) begin
                if (segments_due.size() == 0) begin
                    $error("segment word with none expected: tdata %h tlast %0d",
                           m_tdata, m_tlast);
                    errs++;
                end else begin
                    want = segments_due.pop_front();
                    if (m_tdata[0] !== want.level) begin
                        $error("pin_level: expected %0d, actual %0d", want.level, m_tdata[0]);
                        errs++;
                    end
                    if (m_tdata[16:1] !== want.ticks) begin
                        $error("duration: expected %0d, actual %0d", want.ticks, m_tdata[16:1]);
                        errs++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("is_last: expected %0d, actual %0d", want.last, m_tlast);
                        errs++;
                    end
                    segs_checked <= segs_checked + 1;
                end
            end
            mismatches   <= mismatches + errs;
            segs_pending <= segments_due.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse letter keyer testbench
// Feeds character words under several tick settings, with random stalls on
// both channels and one long output hold-off, and takes the verdict from
// the segment checker.
// ----------------------------------------------------------------------------
module testbench;
    import mlk_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_STALL   = 300;
    localparam int SETTLE       = 8;
    localparam int RANDOM_CHARS = 160;
    localparam int PHASES       = 4;
    localparam logic [MLK_CFG_ADDR_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [MLK_CFG_ADDR_W-1:0] cfg_addr;
    logic [MLK_TICK_W-1:0]     cfg_wdata;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [MLK_S_TDATA_W-1:0]  s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [MLK_M_TDATA_W-1:0]  m_tdata;
    logic                      m_tlast;

    int mismatches;
    int segs_pending;
    int segs_checked;
    int cycles = 0;
    int chars_sent;
    int letters_sent;
    int settings_used;
    bit idle_on;
    int stall_asks;

    morse_letter_keyer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    keyer_segment_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .segs_pending (segs_pending),
        .segs_checked (segs_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // segment receiver: short random stalls, plus one long hold-off on request
    initial begin
        int stalls_done;
        stalls_done = 0;
        m_tready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_asks != stalls_done) begin
                m_tready <= 1'b0;
                repeat (LONG_STALL - 1) @(negedge aclk);
                stalls_done++;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // offer one character word; entered and left at a falling edge
    task automatic send_char(input logic [7:0] c);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        chars_sent++;
        if (c >= CHAR_A && c <= CHAR_Z)
            letters_sent++;
    endtask

    // hold the input and let every expected segment drain out
    task automatic drain;
        s_tvalid <= 1'b0;
        while (segs_pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [MLK_CFG_ADDR_W-1:0] idx,
                             input logic [MLK_TICK_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_ticks(input logic [MLK_TICK_W-1:0] dot,
                             input logic [MLK_TICK_W-1:0] dash,
                             input logic [MLK_TICK_W-1:0] gap);
        write_reg(CFG_DOT_TICKS, dot);
        write_reg(CFG_DASH_TICKS, dash);
        write_reg(CFG_GAP_TICKS, gap);
        settings_used++;
    endtask

    function automatic logic [MLK_TICK_W-1:0] pick_ticks();
        if ($urandom_range(0, 3) == 0)
            return MLK_TICK_W'($urandom_range(1, 8));
        return MLK_TICK_W'($urandom_range(1, 65535));
    endfunction

    initial begin
        logic [7:0] c;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        chars_sent    = 0;
        letters_sent  = 0;
        settings_used = 1;
        idle_on    = 1'b1;
        stall_asks = 0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset tick values: letter ends, longest patterns, non-letters around the range
        send_char("A");
        send_char("Z");
        send_char("E");
        send_char("T");
        send_char("Q");
        send_char(8'd0);
        send_char(8'd255);
        send_char("a");
        send_char(" ");
        send_char("0");
        send_char(CHAR_A - 8'd1);
        send_char(CHAR_Z + 8'd1);
        send_char(8'd127);
        send_char(8'd128);
        drain();

        set_ticks(16'd1, 16'd1, 16'd1);
        send_char("B");
        send_char("J");
        send_char("~");
        drain();

        set_ticks(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_char("Y");
        send_char("H");
        send_char("z");
        drain();

        // zero is taken as is
        set_ticks(16'd0, 16'd0, 16'd0);
        send_char("K");
        send_char("!");
        drain();

        // write to the unused index must change nothing
        set_ticks(16'd7, 16'd21, 16'd99);
        write_reg(CFG_UNUSED_IDX, 16'h5A5A);
        send_char("C");
        send_char("#");
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            set_ticks(pick_ticks(), pick_ticks(), pick_ticks());
            if (ph == 0)
                stall_asks++;
            if (ph == PHASES - 1)
                idle_on = 1'b0;
            for (int i = 0; i < RANDOM_CHARS / PHASES; i++) begin
                if ($urandom_range(0, 9) < 7)
                    c = 8'($urandom_range(CHAR_A, CHAR_Z));
                else
                    c = 8'($urandom_range(0, 255));
                send_char(c);
            end
            drain();
        end

        repeat (SETTLE) @(posedge aclk);
        $display("run: %0d characters (%0d letters) keyed into %0d checked segment words",
                 chars_sent, letters_sent, segs_checked);
        $display("run: %0d tick settings incl. minimum, maximum, zero and an unused index",
                 settings_used);
        if (mismatches == 0 && segs_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/mlk_pkg.sv
hw/rtl/mlk_front.sv
hw/rtl/mlk_queue.sv
hw/rtl/mlk_back.sv
hw/rtl/morse_letter_keyer_top.sv
tb/keyer_segment_checker.sv
tb/testbench.sv
